>>> design/nearest_neighbour_image_scaler_macros.svh
`ifndef NEAREST_NEIGHBOUR_IMAGE_SCALER_MACROS_SVH
`define NEAREST_NEIGHBOUR_IMAGE_SCALER_MACROS_SVH

// Concurrent assertion that holds at every clock edge outside reset.
`define NNS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Concurrent assertion with an antecedent, checked outside reset.
`define NNS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> design/nns_pkg.sv
`timescale 1ns / 1ps

package nns_pkg;

  localparam int MAX_SIDE = 256;
  localparam int COORD_W = $clog2(MAX_SIDE);
  localparam int SIZE_W = COORD_W + 1;
  localparam int ADDR_W = 2 * COORD_W;
  localparam int PROD_W = 2 * COORD_W;
  localparam int DIV_CNT_W = (COORD_W > 1) ? $clog2(COORD_W) : 1;
  localparam int CH_W = 9;
  localparam int IN_CH_W = 11;
  localparam int PIX_W = 3 * CH_W;
  localparam int Q8_ONE = 256;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_X_GO,
    ST_X_WAIT,
    ST_Y_GO,
    ST_Y_WAIT,
    ST_READ,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic start;
    logic [PROD_W-1:0] dividend;
    logic [SIZE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [COORD_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > SIZE_W'(MAX_SIDE)) begin
      r = SIZE_W'(MAX_SIDE);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [CH_W-1:0] clamp_ch(input logic signed [IN_CH_W-1:0] v);
    logic [CH_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed(IN_CH_W'(Q8_ONE))) begin
      r = CH_W'(Q8_ONE);
    end else begin
      r = v[CH_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> design/nns_ram.sv
`timescale 1ns / 1ps

module nns_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/nns_div.sv
`timescale 1ns / 1ps

module nns_div import nns_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 run_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [PROD_W-1:0]    rem_r;
  logic [PROD_W-1:0]    dvs_r;
  logic [COORD_W-1:0]   quo_r;
  logic                 ge;

  // The quotient is known to be below MAX_SIDE, so only COORD_W steps are needed.
  assign ge = (rem_r >= dvs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(COORD_W - 1)) begin
          run_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.dividend;
      dvs_r <= PROD_W'(req.divisor) << (COORD_W - 1);
      quo_r <= '0;
    end else if (run_r) begin
      if (ge) begin
        rem_r <= rem_r - dvs_r;
      end
      quo_r <= (quo_r << 1) | COORD_W'(ge);
      dvs_r <= dvs_r >> 1;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quotient = quo_r;

endmodule

>>> design/nearest_neighbour_image_scaler.sv
// Loads may arrive back to back; no result is produced.
// A fetch outside the destination returns black in the cycle after its request.
// A fetch inside reaches its result through two 8-step passes of the shared divider.
// Results cannot be stalled; out_valid marks each for a single cycle.
// After reset the frame store is cleared with busy high.
`timescale 1ns / 1ps

module nearest_neighbour_image_scaler import nns_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_op,
  input  logic [COORD_W-1:0]        in_pos_x,
  input  logic [COORD_W-1:0]        in_pos_y,
  input  logic signed [IN_CH_W-1:0] in_red_in,
  input  logic signed [IN_CH_W-1:0] in_green_in,
  input  logic signed [IN_CH_W-1:0] in_blue_in,
  output logic                      out_valid,
  output logic [CH_W-1:0]           out_red_out,
  output logic [CH_W-1:0]           out_green_out,
  output logic [CH_W-1:0]           out_blue_out,
  output logic                      out_in_range,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [SIZE_W-1:0]         cfg_data
);

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_r;
  logic [SIZE_W-1:0]   sw_r, sh_r, dw_r, dh_r;
  logic [SIZE_W-1:0]   sw_eff, sh_eff, dw_eff, dh_eff;
  logic [PROD_W-1:0]   prod_x_r, prod_y_r;
  logic [SIZE_W-1:0]   dw_eff_r, dh_eff_r;
  logic [COORD_W-1:0]  qx_r, qy_r;
  logic                accept, load_ok, fetch_in, fetch_out;
  logic                out_valid_r, in_range_r;
  logic [CH_W-1:0]     red_r, green_r, blue_r;
  div_req_t            div_req;
  div_rsp_t            div_rsp;
  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [PIX_W-1:0]    ram_wdata, ram_rdata;
  pixel_t              load_pix, read_pix;

  assign sw_eff = eff_size(sw_r);
  assign sh_eff = eff_size(sh_r);
  assign dw_eff = eff_size(dw_r);
  assign dh_eff = eff_size(dh_r);

  assign accept = start && (state_r == ST_IDLE);
  assign load_ok = accept && (in_op == OP_LOAD) &&
                   (SIZE_W'(in_pos_x) < sw_eff) && (SIZE_W'(in_pos_y) < sh_eff);
  assign fetch_in = accept && (in_op == OP_FETCH) &&
                    (SIZE_W'(in_pos_x) < dw_eff) && (SIZE_W'(in_pos_y) < dh_eff);
  assign fetch_out = accept && (in_op == OP_FETCH) && !fetch_in;

  assign load_pix.red = clamp_ch(in_red_in);
  assign load_pix.green = clamp_ch(in_green_in);
  assign load_pix.blue = clamp_ch(in_blue_in);
  assign read_pix = pixel_t'(ram_rdata);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r <= SIZE_W'(MAX_SIDE);
      sh_r <= SIZE_W'(MAX_SIDE);
      dw_r <= SIZE_W'(MAX_SIDE);
      dh_r <= SIZE_W'(MAX_SIDE);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SRC_WIDTH: sw_r <= cfg_data;
        REG_SRC_HEIGHT: sh_r <= cfg_data;
        REG_DST_WIDTH: dw_r <= cfg_data;
        REG_DST_HEIGHT: dh_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + ADDR_W'(1);
      end
      out_valid_r <= (state_r == ST_RESP) || fetch_out;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_r == '1) state_nxt = ST_IDLE;
      ST_IDLE: if (fetch_in) state_nxt = ST_X_GO;
      ST_X_GO: state_nxt = ST_X_WAIT;
      ST_X_WAIT: if (div_rsp.done) state_nxt = ST_Y_GO;
      ST_Y_GO: state_nxt = ST_Y_WAIT;
      ST_Y_WAIT: if (div_rsp.done) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_RESP;
      ST_RESP: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b1;
    div_req.start = 1'b0;
    div_req.dividend = prod_x_r;
    div_req.divisor = dw_eff_r;
    ram_we = 1'b0;
    ram_waddr = {in_pos_y, in_pos_x};
    ram_wdata = load_pix;
    ram_re = 1'b0;
    ram_raddr = {qy_r, qx_r};
    case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        busy = 1'b0;
        ram_we = load_ok;
      end
      ST_X_GO: begin
        div_req.start = 1'b1;
      end
      ST_Y_GO: begin
        div_req.start = 1'b1;
        div_req.dividend = prod_y_r;
        div_req.divisor = dh_eff_r;
      end
      ST_READ: begin
        ram_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod_x_r <= PROD_W'(in_pos_x) * PROD_W'(sw_eff);
      prod_y_r <= PROD_W'(in_pos_y) * PROD_W'(sh_eff);
      dw_eff_r <= dw_eff;
      dh_eff_r <= dh_eff;
    end
    if ((state_r == ST_X_WAIT) && div_rsp.done) begin
      qx_r <= div_rsp.quotient;
    end
    if ((state_r == ST_Y_WAIT) && div_rsp.done) begin
      qy_r <= div_rsp.quotient;
    end
    if (state_r == ST_RESP) begin
      red_r <= read_pix.red;
      green_r <= read_pix.green;
      blue_r <= read_pix.blue;
      in_range_r <= 1'b1;
    end else if (fetch_out) begin
      red_r <= '0;
      green_r <= '0;
      blue_r <= '0;
      in_range_r <= 1'b0;
    end
  end

  nns_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  nns_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_SIDE * MAX_SIDE)
  ) u_frame_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_red_out = red_r;
  assign out_green_out = green_r;
  assign out_blue_out = blue_r;
  assign out_in_range = in_range_r;

endmodule

>>> design/nns_sva.sv
`timescale 1ns / 1ps
`include "nearest_neighbour_image_scaler_macros.svh"

module nns_sva import nns_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  input logic            start,
  input logic            busy,
  input logic            in_op,
  input logic            out_valid,
  input logic [CH_W-1:0] out_red_out,
  input logic [CH_W-1:0] out_green_out,
  input logic [CH_W-1:0] out_blue_out,
  input logic            out_in_range
);

  logic outside_rsp;
  logic out_black;
  logic out_capped;
  logic req_cause;

  assign outside_rsp = out_valid && !out_in_range;
  assign out_black = (out_red_out == '0) && (out_green_out == '0) && (out_blue_out == '0);
  assign out_capped = (out_red_out <= CH_W'(Q8_ONE)) && (out_green_out <= CH_W'(Q8_ONE)) &&
                      (out_blue_out <= CH_W'(Q8_ONE));
  assign req_cause = busy || (start && (in_op == OP_FETCH));

  `NNS_ASSERT_IMP(a_clear_after_reset, clk, rst_n, $past(!rst_n), busy, "store clear not running")
  `NNS_ASSERT_IMP(a_black_outside, clk, rst_n, outside_rsp, out_black, "nonblack outside result")
  `NNS_ASSERT_IMP(a_channel_max, clk, rst_n, out_valid, out_capped, "channel above one")
  `NNS_ASSERT_IMP(a_result_cause, clk, rst_n, out_valid, $past(req_cause), "result without fetch")

endmodule

bind nearest_neighbour_image_scaler nns_sva u_nns_sva (.*);

>>> bench/tb_nearest_neighbour_image_scaler.sv
`timescale 1ns / 1ps

module tb_nearest_neighbour_image_scaler;
  import nns_pkg::*;

  localparam int SETTLE_CYCLES = 30;

  typedef struct packed {
    pixel_t color;
    logic   in_range;
  } fetched_pixel_t;

  class resize_tracker;
    pixel_t            frame [MAX_SIDE*MAX_SIDE];
    logic [SIZE_W-1:0] sizes [4];
    fetched_pixel_t    awaited_pixels [$];
    int unsigned       mismatches;

    function new();
      foreach (frame[i]) frame[i] = '0;
      foreach (sizes[i]) sizes[i] = SIZE_W'(MAX_SIDE);
      mismatches = 0;
    endfunction

    function int unsigned side(input logic [CFG_IDX_W-1:0] idx);
      int unsigned v;
      v = sizes[idx];
      if (v == 0) begin
        v = 1;
      end else if (v > MAX_SIDE) begin
        v = MAX_SIDE;
      end
      return v;
    endfunction

    function logic [CH_W-1:0] saturate(input logic signed [IN_CH_W-1:0] v);
      if (v < 0) return '0;
      if (v > Q8_ONE) return CH_W'(Q8_ONE);
      return v[CH_W-1:0];
    endfunction

    function int unsigned nearest(input int unsigned d, input int unsigned s,
                                  input int unsigned dd);
      int unsigned q;
      q = (d * s) / dd;
      return (q >= s) ? s - 1 : q;
    endfunction

    function void note_request(input logic op, input logic [COORD_W-1:0] x,
                               input logic [COORD_W-1:0] y,
                               input logic signed [IN_CH_W-1:0] r,
                               input logic signed [IN_CH_W-1:0] g,
                               input logic signed [IN_CH_W-1:0] b);
      int unsigned sw, sh, dw, dh;
      fetched_pixel_t res;
      sw = side(REG_SRC_WIDTH);
      sh = side(REG_SRC_HEIGHT);
      dw = side(REG_DST_WIDTH);
      dh = side(REG_DST_HEIGHT);
      if (op == OP_LOAD) begin
        if (x < sw && y < sh) begin
          frame[int'(y) * MAX_SIDE + int'(x)] =
            '{blue: saturate(b), green: saturate(g), red: saturate(r)};
        end
      end else begin
        res = '0;
        if (x < dw && y < dh) begin
          res.color = frame[nearest(y, sh, dh) * MAX_SIDE + nearest(x, sw, dw)];
          res.in_range = 1'b1;
        end
        awaited_pixels.push_back(res);
      end
    endfunction

    function void compare_field(input string name, input int want, input int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                              input logic [CH_W-1:0] b, input logic inr);
      fetched_pixel_t want;
      if (awaited_pixels.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d %0d %0d in_range %0b",
                 $time, r, g, b, inr);
        mismatches++;
        return;
      end
      want = awaited_pixels.pop_front();
      compare_field("red_out", want.color.red, r);
      compare_field("green_out", want.color.green, g);
      compare_field("blue_out", want.color.blue, b);
      compare_field("in_range", want.in_range, inr);
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      in_op = OP_LOAD;
  logic [COORD_W-1:0]        in_pos_x = '0;
  logic [COORD_W-1:0]        in_pos_y = '0;
  logic signed [IN_CH_W-1:0] in_red_in = '0;
  logic signed [IN_CH_W-1:0] in_green_in = '0;
  logic signed [IN_CH_W-1:0] in_blue_in = '0;
  logic                      out_valid;
  logic [CH_W-1:0]           out_red_out;
  logic [CH_W-1:0]           out_green_out;
  logic [CH_W-1:0]           out_blue_out;
  logic                      out_in_range;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = REG_SRC_WIDTH;
  logic [SIZE_W-1:0]         cfg_data = '0;

  resize_tracker tracker;

  nearest_neighbour_image_scaler i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_red_in     (in_red_in),
    .in_green_in   (in_green_in),
    .in_blue_in    (in_blue_in),
    .out_valid     (out_valid),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out),
    .out_in_range  (out_in_range),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      tracker.check_pixel(out_red_out, out_green_out, out_blue_out, out_in_range);
    end
  end

  task automatic send_request(input logic op, input int x, input int y,
                              input int r, input int g, input int b);
    in_op <= op;
    in_pos_x <= COORD_W'(x);
    in_pos_y <= COORD_W'(y);
    in_red_in <= IN_CH_W'(r);
    in_green_in <= IN_CH_W'(g);
    in_blue_in <= IN_CH_W'(b);
    start <= 1'b1;
    do @(posedge clk); while (busy);
    tracker.note_request(in_op, in_pos_x, in_pos_y, in_red_in, in_green_in, in_blue_in);
  endtask

  task automatic pause(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Fetches may still be in flight behind a trailing load, so settle afterwards.
  task automatic drain_results();
    start <= 1'b0;
    while (tracker.awaited_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input int sw, input int sh, input int dw, input int dh);
    logic [CFG_IDX_W-1:0] regs [4];
    int vals [4];
    regs = '{REG_SRC_WIDTH, REG_SRC_HEIGHT, REG_DST_WIDTH, REG_DST_HEIGHT};
    vals = '{sw, sh, dw, dh};
    for (int i = 0; i < 4; i++) begin
      cfg_index <= regs[i];
      cfg_data <= SIZE_W'(vals[i]);
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      tracker.sizes[regs[i]] = SIZE_W'(vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_channel();
    int corners [6];
    corners = '{-1024, -1, 0, 256, 257, 1023};
    case ($urandom_range(9))
      0, 1, 2: return int'($urandom_range(2047)) - 1024;
      3: return corners[$urandom_range(5)];
      default: return $urandom_range(256);
    endcase
  endfunction

  function automatic int pick_size();
    if ($urandom_range(3) == 0) return $urandom_range(511);
    return $urandom_range(1, 24);
  endfunction

  task automatic random_request();
    int unsigned w, h;
    int x, y;
    logic op;
    op = $urandom_range(1) ? OP_FETCH : OP_LOAD;
    if (op == OP_LOAD) begin
      w = tracker.side(REG_SRC_WIDTH);
      h = tracker.side(REG_SRC_HEIGHT);
    end else begin
      w = tracker.side(REG_DST_WIDTH);
      h = tracker.side(REG_DST_HEIGHT);
    end
    if ($urandom_range(9) < 8) begin
      x = $urandom_range(w - 1);
      y = $urandom_range(h - 1);
    end else begin
      x = $urandom_range(255);
      y = $urandom_range(255);
    end
    send_request(op, x, y, pick_channel(), pick_channel(), pick_channel());
  endtask

  task automatic run_phase(input int count, input int idle_pct, input bit hold_midway);
    int gap;
    for (int k = 0; k < count; k++) begin
      random_request();
      if (hold_midway && k == count / 2) begin
        start <= 1'b0;
        while (tracker.awaited_pixels.size() != 0) @(posedge clk);
      end else if (idle_pct > 0 && $urandom_range(99) < 3) begin
        pause($urandom_range(1, 40));
      end else begin
        gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
        if (gap > 0) pause(gap);
      end
    end
  endtask

  initial begin
    int idle_modes [3];
    idle_modes = '{0, 46, 11};
    tracker = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Channel saturation and the corners of the full-size store.
    send_request(OP_LOAD, 0, 0, -1024, 0, 1023);
    send_request(OP_LOAD, 255, 255, 256, 257, -1);
    send_request(OP_LOAD, 1, 0, 1, 255, 128);
    send_request(OP_LOAD, 0, 1, -1, 1023, 100);
    send_request(OP_FETCH, 0, 0, 0, 0, 0);
    send_request(OP_FETCH, 255, 255, 0, 0, 0);
    send_request(OP_FETCH, 1, 0, 0, 0, 0);
    send_request(OP_FETCH, 0, 1, 0, 0, 0);
    send_request(OP_FETCH, 2, 2, 0, 0, 0);
    drain_results();

    // Single-pixel images: loads and fetches off the edge.
    configure(1, 1, 1, 1);
    send_request(OP_LOAD, 0, 0, 77, -5, 300);
    send_request(OP_LOAD, 1, 0, 10, 10, 10);
    send_request(OP_LOAD, 0, 1, 20, 20, 20);
    send_request(OP_FETCH, 0, 0, 0, 0, 0);
    send_request(OP_FETCH, 1, 0, 0, 0, 0);
    send_request(OP_FETCH, 0, 1, 0, 0, 0);
    send_request(OP_FETCH, 255, 255, 0, 0, 0);
    drain_results();

    // Zero acts as one and oversized values act as the maximum.
    configure(0, 0, 511, 300);
    send_request(OP_FETCH, 255, 255, 0, 0, 0);
    send_request(OP_FETCH, 128, 0, 0, 0, 0);
    drain_results();

    // Old pixels keep their place after the source grows again.
    configure(256, 256, 128, 128);
    send_request(OP_FETCH, 127, 127, 0, 0, 0);
    send_request(OP_FETCH, 128, 0, 0, 0, 0);
    drain_results();

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: configure(8, 6, 20, 15);
        1: configure(200, 180, 7, 9);
        2: configure(16, 16, 16, 16);
        3: configure(511, 511, 1, 1);
        default: configure(pick_size(), pick_size(), pick_size(), pick_size());
      endcase
      run_phase(103, idle_modes[p % 3], p % 4 == 1);
      drain_results();
    end

    if (tracker.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/nns_pkg.sv
design/nns_ram.sv
design/nns_div.sv
design/nearest_neighbour_image_scaler.sv
design/nns_sva.sv
bench/tb_nearest_neighbour_image_scaler.sv
